// ===== design/rcd_pkg.sv =====
// ----------------------------------------------------------------------------
// rcd_pkg
// Shared types, constants and helpers for the read command deque.
// ----------------------------------------------------------------------------
package rcd_pkg;

  // Number of command slots in the ring.
  localparam int unsigned QUEUE_DEPTH = 32;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ECNT_W      = 6;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Request codes carried in req_type.
  typedef enum logic [2:0] {
    REQ_PUSH_TAIL = 3'd0,
    REQ_PUSH_HEAD = 3'd1,
    REQ_POP       = 3'd2,
    REQ_PEEK      = 3'd3,
    REQ_DROP_K12  = 3'd4,
    REQ_DROP_K3   = 3'd5
  } req_code_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2
  } status_e;

  // Kind codes that the flushes look at.
  localparam logic [2:0] KIND_RETRY_A = 3'd1;
  localparam logic [2:0] KIND_RETRY_B = 3'd2;
  localparam logic [2:0] KIND_PREFETCH = 3'd3;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RESP,
    ST_WALK
  } rcd_state_e;

  // One stored command.
  typedef struct packed {
    logic [31:0] sector_addr;
    logic [31:0] sector_count;
    logic [31:0] buffer_addr;
    logic [2:0]  kind;
    logic [31:0] due_time;
  } entry_t;

  // Request payload.
  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] sector_addr;
    logic [31:0] sector_count;
    logic [31:0] buffer_addr;
    logic [2:0]  kind;
    logic [31:0] due_time;
  } req_t;

  // Result payload.
  typedef struct packed {
    logic [31:0]       head_sector_addr;
    logic [31:0]       head_sector_count;
    logic [31:0]       head_buffer_addr;
    logic [2:0]        head_kind;
    logic [31:0]       head_due_time;
    logic [ECNT_W-1:0] entry_count;
    logic [1:0]        status;
  } rsp_t;

  // Memory access from the sequencer: one write and one read port.
  typedef struct packed {
    logic   we;
    ptr_t   waddr;
    entry_t wdata;
    logic   re;
    ptr_t   raddr;
  } mem_req_t;

  // Result control from the sequencer to the output register.
  typedef struct packed {
    logic    load;
    logic    show;
    cnt_t    count;
    status_e status;
  } rsp_ctl_t;

  // Ring pointer steps.
  function automatic ptr_t next_ptr(input ptr_t p);
    return (p == ptr_t'(QUEUE_DEPTH - 1)) ? '0 : p + ptr_t'(1);
  endfunction

  function automatic ptr_t prev_ptr(input ptr_t p);
    return (p == '0) ? ptr_t'(QUEUE_DEPTH - 1) : p - ptr_t'(1);
  endfunction

endpackage

// ===== design/rcd_if.sv =====
// ----------------------------------------------------------------------------
// rcd_if
// Valid/ready channels for requests into and results out of the deque.
// ----------------------------------------------------------------------------
interface rcd_req_if import rcd_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rcd_rsp_if import rcd_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/rcd_mem.sv =====
// ----------------------------------------------------------------------------
// rcd_mem
// Command store: one write and one read port, registered read data, with
// write-to-read forwarding when both ports hit the same slot.
// ----------------------------------------------------------------------------
module rcd_mem import rcd_pkg::*; (
  input  logic     clk_i,
  input  mem_req_t mem_req_i,
  output entry_t   rd_entry_o
);

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_entry_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      mem[mem_req_i.waddr] <= mem_req_i.wdata;
    end
  end

  // Read port; a same-cycle write to the read slot is passed straight through.
  always_ff @(posedge clk_i) begin
    if (mem_req_i.re) begin
      if (mem_req_i.we && (mem_req_i.waddr == mem_req_i.raddr)) begin
        rd_entry_q <= mem_req_i.wdata;
      end else begin
        rd_entry_q <= mem[mem_req_i.raddr];
      end
    end
  end

  assign rd_entry_o = rd_entry_q;

endmodule

// ===== design/rcd_ctrl.sv =====
// ----------------------------------------------------------------------------
// rcd_ctrl
// Deque sequencer: keeps head, tail and fill count, issues store accesses for
// each request and walks the store during a filtered flush.
// ----------------------------------------------------------------------------
module rcd_ctrl import rcd_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  rcd_req_if.sink        req_i,
  input  entry_t         rd_entry_i,
  input  logic           out_free_i,
  output mem_req_t       mem_req_o,
  output rsp_ctl_t       rsp_ctl_o
);

  rcd_state_e state_q, state_d;
  ptr_t       head_q, head_d;
  ptr_t       tail_q, tail_d;
  cnt_t       cnt_q, cnt_d;
  cnt_t       rem_q, rem_d;
  ptr_t       rdp_q, rdp_d;
  logic       flv_q, flv_d;
  logic       kmode_q, kmode_d;
  logic       pend_show_q, pend_show_d;
  cnt_t       pend_cnt_q, pend_cnt_d;
  status_e    pend_sts_q, pend_sts_d;

  logic   accept;
  logic   is_drop;
  logic   full;
  logic   empty;
  logic   walk_done;
  logic   keep;
  entry_t req_entry;
  ptr_t   new_head;

  // Handshake and simple conditions.
  assign req_i.ready = (state_q == ST_IDLE) || ((state_q == ST_RESP) && out_free_i);
  assign accept      = req_i.valid && req_i.ready;
  assign is_drop     = (req_i.data.req_type == REQ_DROP_K12) ||
                       (req_i.data.req_type == REQ_DROP_K3);
  assign full        = (cnt_q == cnt_t'(QUEUE_DEPTH));
  assign empty       = (cnt_q == '0);
  assign walk_done   = (rem_q == '0) && !flv_q;
  assign new_head    = prev_ptr(head_q);

  // Survivor test for the entry coming back from the store during a flush.
  assign keep = kmode_q ? (rd_entry_i.kind != KIND_PREFETCH)
                        : ((rd_entry_i.kind != KIND_RETRY_A) &&
                           (rd_entry_i.kind != KIND_RETRY_B));

  assign req_entry = '{
    sector_addr:  req_i.data.sector_addr,
    sector_count: req_i.data.sector_count,
    buffer_addr:  req_i.data.buffer_addr,
    kind:         req_i.data.kind,
    due_time:     req_i.data.due_time
  };

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = is_drop ? ST_WALK : ST_RESP;
        end
      end
      ST_RESP: begin
        if (accept) begin
          state_d = is_drop ? ST_WALK : ST_RESP;
        end else if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      ST_WALK: begin
        if (walk_done) begin
          state_d = ST_RESP;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Store accesses, pointer updates and pending result.
  always_comb begin
    mem_req_o   = '0;
    head_d      = head_q;
    tail_d      = tail_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    rdp_d       = rdp_q;
    flv_d       = 1'b0;
    kmode_d     = kmode_q;
    pend_show_d = pend_show_q;
    pend_cnt_d  = pend_cnt_q;
    pend_sts_d  = pend_sts_q;

    if (accept) begin
      pend_sts_d      = STS_OK;
      pend_show_d     = !empty;
      mem_req_o.re    = 1'b1;
      mem_req_o.raddr = head_q;
      mem_req_o.wdata = req_entry;
      case (req_i.data.req_type)
        REQ_PUSH_TAIL: begin
          if (full) begin
            pend_sts_d = STS_FULL;
          end else begin
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = tail_q;
            tail_d          = next_ptr(tail_q);
            cnt_d           = cnt_q + cnt_t'(1);
            pend_show_d     = 1'b1;
          end
        end
        REQ_PUSH_HEAD: begin
          if (full) begin
            pend_sts_d = STS_FULL;
          end else begin
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = new_head;
            mem_req_o.raddr = new_head;
            head_d          = new_head;
            cnt_d           = cnt_q + cnt_t'(1);
            pend_show_d     = 1'b1;
          end
        end
        REQ_POP: begin
          if (empty) begin
            pend_sts_d = STS_EMPTY;
          end else begin
            head_d = next_ptr(head_q);
            cnt_d  = cnt_q - cnt_t'(1);
          end
        end
        REQ_PEEK: begin
          if (empty) begin
            pend_sts_d = STS_EMPTY;
          end
        end
        REQ_DROP_K12, REQ_DROP_K3: begin
          // Survivors are rewritten from the old tail onwards.
          mem_req_o.re = 1'b0;
          rem_d        = cnt_q;
          rdp_d        = head_q;
          head_d       = tail_q;
          cnt_d        = '0;
          kmode_d      = (req_i.data.req_type == REQ_DROP_K3);
        end
        default: ;
      endcase
      pend_cnt_d = cnt_d;
    end else if (state_q == ST_WALK) begin
      // Read side of the walk: one old entry a cycle.
      if (rem_q != '0) begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = rdp_q;
        rdp_d           = next_ptr(rdp_q);
        rem_d           = rem_q - cnt_t'(1);
        flv_d           = 1'b1;
      end
      // Write side: append a survivor in the cycle after its read.
      if (flv_q && keep) begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = tail_q;
        mem_req_o.wdata = rd_entry_i;
        tail_d          = next_ptr(tail_q);
        cnt_d           = cnt_q + cnt_t'(1);
      end
      // Walk finished: fetch the new head for the result.
      if (walk_done) begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = head_q;
        pend_cnt_d      = cnt_q;
        pend_show_d     = !empty;
        pend_sts_d      = STS_OK;
      end
    end
  end

  // Result control towards the output register.
  always_comb begin
    rsp_ctl_o.load   = (state_q == ST_RESP) && out_free_i;
    rsp_ctl_o.show   = pend_show_q;
    rsp_ctl_o.count  = pend_cnt_q;
    rsp_ctl_o.status = pend_sts_q;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      cnt_q   <= '0;
      rem_q   <= '0;
      rdp_q   <= '0;
      flv_q   <= 1'b0;
      kmode_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
      rdp_q   <= rdp_d;
      flv_q   <= flv_d;
      kmode_q <= kmode_d;
    end
  end

  // Pending result fields.
  always_ff @(posedge clk_i) begin
    pend_show_q <= pend_show_d;
    pend_cnt_q  <= pend_cnt_d;
    pend_sts_q  <= pend_sts_d;
  end

endmodule

// ===== design/read_command_deque.sv =====
// ----------------------------------------------------------------------------
// read_command_deque
// Ring deque of disc-read commands with head/tail push, pop, peek and two
// filtered flushes that keep the surviving commands in order.
// ----------------------------------------------------------------------------
//   Port     Dir  Handshake      Moves
//   req_i    in   valid/ready    one request: type plus command fields
//   rsp_o    out  valid/ready    one result: head entry, count, status
//
// Push, pop and peek: the store is read when the request is taken and the
// result is loaded into the output register once that register is free, so
// a new request is taken every cycle while the output register drains. A
// flush walks the store one entry a cycle through its read port and writes
// survivors through the write port in the cycle after each read; its result
// is then loaded into the output register once that register is free.
// Reset clears the state, the pointers and the counts; the store is not cleared.
// req_i.ready drops during a flush and while a result waits on rsp_o.
// ----------------------------------------------------------------------------
module read_command_deque import rcd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  rcd_req_if.sink   req_i,
  rcd_rsp_if.source rsp_o
);

  mem_req_t mem_req;
  entry_t   rd_entry;
  rsp_ctl_t rsp_ctl;
  logic     out_free;
  logic     out_vld_q;
  rsp_t     out_data_q;
  entry_t   shown;
  logic [CNT_W+ECNT_W-1:0] cnt_ext;

  rcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .rd_entry_i (rd_entry),
    .out_free_i (out_free),
    .mem_req_o  (mem_req),
    .rsp_ctl_o  (rsp_ctl)
  );

  rcd_mem u_mem (
    .clk_i      (clk_i),
    .mem_req_i  (mem_req),
    .rd_entry_o (rd_entry)
  );

  // Output register: free when empty or being taken this cycle.
  assign out_free = !out_vld_q || rsp_o.ready;
  assign shown    = rsp_ctl.show ? rd_entry : '0;
  assign cnt_ext  = {{ECNT_W{1'b0}}, rsp_ctl.count};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (rsp_ctl.load) begin
      out_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_ctl.load) begin
      out_data_q.head_sector_addr  <= shown.sector_addr;
      out_data_q.head_sector_count <= shown.sector_count;
      out_data_q.head_buffer_addr  <= shown.buffer_addr;
      out_data_q.head_kind         <= shown.kind;
      out_data_q.head_due_time     <= shown.due_time;
      out_data_q.entry_count       <= cnt_ext[ECNT_W-1:0];
      out_data_q.status            <= rsp_ctl.status;
    end
  end

  assign rsp_o.valid = out_vld_q;
  assign rsp_o.data  = out_data_q;

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the read command deque. A scoreboard model of the
// deque predicts the result of every accepted request; each result taken
// from the block is compared field by field against the oldest prediction.
// Directed tests cover the empty and full edges, the spare request codes and
// the order kept by both filtered flushes. Random traffic with bursts of
// idling on both channels follows, then a stretch at full rate.
// ----------------------------------------------------------------------------
module tb;
  import rcd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Request codes that the block treats as no operation.
  localparam logic [2:0] REQ_SPARE_6 = 3'd6;
  localparam logic [2:0] REQ_SPARE_7 = 3'd7;

  // Kind codes that no flush removes.
  localparam logic [2:0] KIND_PLAIN = 3'd0;
  localparam logic [2:0] KIND_TOP   = 3'd7;

  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD   = 300;
  localparam int TAIL_CYCLES = 50;

  logic clk;
  logic rst_n;

  rcd_req_if req_if ();
  rcd_rsp_if rsp_if ();

  read_command_deque dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Scoreboard state: the modelled deque contents and the results still owed.
  entry_t queued_cmds[$];
  rsp_t   awaited_results[$];

  int  mismatches;
  int  results_seen;
  int  requests_sent;
  int  refused_pushes;
  int  empty_reads;
  int  flushes_done;
  int  deepest_fill;
  int  quiet_cycles;
  int  long_hold_cycles;
  bit  hold_active;
  bit  idling_on;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Works out the result of one request and updates the modelled deque.
  function automatic rsp_t predict_result(input req_t r);
    rsp_t   res;
    entry_t cmd;
    entry_t shown;
    entry_t kept[$];
    bit     popped;
    res    = '0;
    shown  = '0;
    popped = 1'b0;
    res.status = STS_OK;
    cmd.sector_addr  = r.sector_addr;
    cmd.sector_count = r.sector_count;
    cmd.buffer_addr  = r.buffer_addr;
    cmd.kind         = r.kind;
    cmd.due_time     = r.due_time;
    case (r.req_type)
      REQ_PUSH_TAIL, REQ_PUSH_HEAD: begin
        if (queued_cmds.size() >= QUEUE_DEPTH) begin
          res.status = STS_FULL;
          refused_pushes++;
        end else if (r.req_type == REQ_PUSH_TAIL) begin
          queued_cmds.push_back(cmd);
        end else begin
          queued_cmds.push_front(cmd);
        end
      end
      REQ_POP: begin
        if (queued_cmds.size() == 0) begin
          res.status = STS_EMPTY;
          empty_reads++;
        end else begin
          shown  = queued_cmds.pop_front();
          popped = 1'b1;
        end
      end
      REQ_PEEK: begin
        if (queued_cmds.size() == 0) begin
          res.status = STS_EMPTY;
          empty_reads++;
        end
      end
      REQ_DROP_K12, REQ_DROP_K3: begin
        // Survivors keep their order from head to tail.
        foreach (queued_cmds[i]) begin
          if (r.req_type == REQ_DROP_K12) begin
            if (queued_cmds[i].kind != KIND_RETRY_A && queued_cmds[i].kind != KIND_RETRY_B)
              kept.push_back(queued_cmds[i]);
          end else if (queued_cmds[i].kind != KIND_PREFETCH) begin
            kept.push_back(queued_cmds[i]);
          end
        end
        queued_cmds = kept;
        flushes_done++;
      end
      default: ;
    endcase
    if (!popped && queued_cmds.size() != 0) shown = queued_cmds[0];
    if (queued_cmds.size() > deepest_fill) deepest_fill = queued_cmds.size();
    res.head_sector_addr  = shown.sector_addr;
    res.head_sector_count = shown.sector_count;
    res.head_buffer_addr  = shown.buffer_addr;
    res.head_kind         = shown.kind;
    res.head_due_time     = shown.due_time;
    res.entry_count       = ECNT_W'(queued_cmds.size());
    return res;
  endfunction

  // Prints one mismatch and counts it.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("mismatch at result %0d: %s got %h expected %h", results_seen, what, got, want);
  endtask

  function automatic req_t make_req(input logic [2:0] code, input logic [31:0] sa,
                                    input logic [31:0] sc, input logic [31:0] ba,
                                    input logic [2:0] kd, input logic [31:0] dt);
    req_t r;
    r.req_type     = code;
    r.sector_addr  = sa;
    r.sector_count = sc;
    r.buffer_addr  = ba;
    r.kind         = kd;
    r.due_time     = dt;
    return r;
  endfunction

  // Random command fields; kinds lean towards the ones the flushes look at.
  function automatic req_t rand_req(input logic [2:0] code);
    logic [2:0] kd;
    kd = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 3));
    return make_req(code, $urandom, $urandom, $urandom, kd, $urandom);
  endfunction

  // Offers one request and returns at the edge where it is taken. Valid is
  // left high so that back-to-back requests need no second assignment.
  task automatic send_request(input req_t r);
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    awaited_results.push_back(predict_result(r));
    requests_sent++;
  endtask

  task automatic idle_gap(input int n);
    req_if.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Sends a request, then sometimes idles for a burst.
  task automatic send_with_gap(input req_t r);
    send_request(r);
    if (idling_on && $urandom_range(0, 5) == 0) idle_gap($urandom_range(1, 15));
  endtask

  // Holds off the sender until every owed result has arrived.
  task automatic wait_results_drained();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // Picks a request code; fill mode favours pushes, drain mode favours pops.
  function automatic logic [2:0] pick_code(input bit fill_mode);
    int p;
    p = $urandom_range(0, 99);
    if (fill_mode) begin
      if (p < 60) return REQ_PUSH_TAIL;
      if (p < 75) return REQ_PUSH_HEAD;
      if (p < 85) return REQ_POP;
      if (p < 90) return REQ_PEEK;
    end else begin
      if (p < 18) return REQ_PUSH_TAIL;
      if (p < 27) return REQ_PUSH_HEAD;
      if (p < 80) return REQ_POP;
      if (p < 88) return REQ_PEEK;
    end
    if (p < 93) return REQ_DROP_K12;
    if (p < 97) return REQ_DROP_K3;
    return (p < 98) ? REQ_SPARE_6 : REQ_SPARE_7;
  endfunction

  // Reads, flushes and spare codes on an empty deque.
  task automatic test_empty_deque();
    send_with_gap(rand_req(REQ_PEEK));
    send_with_gap(rand_req(REQ_POP));
    send_with_gap(rand_req(REQ_DROP_K12));
    send_with_gap(rand_req(REQ_DROP_K3));
    send_with_gap(rand_req(REQ_SPARE_6));
    send_with_gap(rand_req(REQ_SPARE_7));
  endtask

  // Field extremes through both push ends, peek and pop.
  task automatic test_push_extremes();
    send_with_gap(make_req(REQ_PUSH_TAIL, '1, '1, '1, KIND_TOP, '1));
    send_with_gap(make_req(REQ_PUSH_TAIL, '0, '0, '0, KIND_PLAIN, '0));
    send_with_gap(make_req(REQ_PUSH_HEAD, 32'hA5A5_5A5A, 32'h5A5A_A5A5, 32'h0F0F_F0F0,
                           KIND_RETRY_B, 32'hF0F0_0F0F));
    send_with_gap(rand_req(REQ_PEEK));
    send_with_gap(rand_req(REQ_POP));
    send_with_gap(rand_req(REQ_POP));
    send_with_gap(rand_req(REQ_POP));
    send_with_gap(rand_req(REQ_POP));
  endtask

  // Both flushes on a mix of kinds; the survivors must come out in order.
  task automatic test_flush_order();
    send_with_gap(make_req(REQ_PUSH_TAIL, $urandom, $urandom, $urandom, KIND_RETRY_A, $urandom));
    send_with_gap(make_req(REQ_PUSH_TAIL, $urandom, $urandom, $urandom, KIND_PREFETCH, $urandom));
    send_with_gap(make_req(REQ_PUSH_HEAD, $urandom, $urandom, $urandom, KIND_PLAIN, $urandom));
    send_with_gap(make_req(REQ_PUSH_TAIL, $urandom, $urandom, $urandom, KIND_RETRY_B, $urandom));
    send_with_gap(make_req(REQ_PUSH_TAIL, $urandom, $urandom, $urandom, KIND_PREFETCH, $urandom));
    send_with_gap(make_req(REQ_PUSH_TAIL, $urandom, $urandom, $urandom, KIND_TOP, $urandom));
    send_with_gap(rand_req(REQ_DROP_K12));
    send_with_gap(rand_req(REQ_DROP_K3));
    send_with_gap(rand_req(REQ_POP));
    send_with_gap(rand_req(REQ_POP));
  endtask

  // The receiver stalls for a long stretch while pushes keep coming, so the
  // deque fills, refuses pushes and stalls its input. Then the sender waits
  // for every result, and full-depth flushes and a drain to empty follow.
  task automatic test_backpressure_fill();
    long_hold_cycles = LONG_HOLD;
    req_if.valid <= 1'b0;
    while (!hold_active) @(posedge clk);
    for (int i = 0; i < 36; i++) send_request(rand_req(REQ_PUSH_TAIL));
    send_request(rand_req(REQ_PUSH_HEAD));
    send_request(rand_req(REQ_SPARE_7));
    wait_results_drained();
    send_with_gap(rand_req(REQ_DROP_K3));
    while (queued_cmds.size() < QUEUE_DEPTH) send_with_gap(rand_req(REQ_PUSH_HEAD));
    send_with_gap(rand_req(REQ_DROP_K12));
    while (queued_cmds.size() != 0) send_with_gap(rand_req(REQ_POP));
    send_with_gap(rand_req(REQ_POP));
    wait_results_drained();
  endtask

  // Random traffic in runs that alternately fill and drain the deque.
  task automatic test_random_traffic(input int n_items);
    int  sent;
    int  run_len;
    bit  fill_mode;
    sent = 0;
    while (sent < n_items) begin
      fill_mode = ~fill_mode;
      run_len   = $urandom_range(20, 60);
      for (int i = 0; i < run_len && sent < n_items; i++) begin
        send_with_gap(rand_req(pick_code(fill_mode)));
        sent++;
      end
      if ($urandom_range(0, 7) == 0) wait_results_drained();
    end
  endtask

  // Final stretch with no idling on either side.
  task automatic test_full_rate(input int n_items);
    idling_on = 1'b0;
    for (int i = 0; i < n_items; i++) send_request(rand_req(pick_code(i[5])));
  endtask

  // Result receiver: random stall bursts, a long hold on request.
  initial begin : result_sink
    int n;
    rsp_if.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_cycles != 0) begin
        n = long_hold_cycles;
        hold_active = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (n) @(posedge clk);
        long_hold_cycles = 0;
        hold_active = 1'b0;
      end else if (idling_on && $urandom_range(0, 3) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        rsp_if.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Compares each taken result with the oldest prediction.
  always @(posedge clk) begin : result_check
    rsp_t got;
    rsp_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      got = rsp_if.data;
      if (awaited_results.size() == 0) begin
        report_mismatch("result with none owed", '0, '0);
      end else begin
        want = awaited_results.pop_front();
        if (got.head_sector_addr !== want.head_sector_addr)
          report_mismatch("head_sector_addr", got.head_sector_addr, want.head_sector_addr);
        if (got.head_sector_count !== want.head_sector_count)
          report_mismatch("head_sector_count", got.head_sector_count, want.head_sector_count);
        if (got.head_buffer_addr !== want.head_buffer_addr)
          report_mismatch("head_buffer_addr", got.head_buffer_addr, want.head_buffer_addr);
        if (got.head_kind !== want.head_kind)
          report_mismatch("head_kind", 32'(got.head_kind), 32'(want.head_kind));
        if (got.head_due_time !== want.head_due_time)
          report_mismatch("head_due_time", got.head_due_time, want.head_due_time);
        if (got.entry_count !== want.entry_count)
          report_mismatch("entry_count", 32'(got.entry_count), 32'(want.entry_count));
        if (got.status !== want.status)
          report_mismatch("status", 32'(got.status), 32'(want.status));
      end
      results_seen++;
    end
  end

  // Watchdog: ends the run after too long without any handshake.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results owed",
               quiet_cycles, awaited_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rst_n        = 1'b0;
    idling_on    = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_deque();
    test_push_extremes();
    test_flush_order();
    test_backpressure_fill();
    test_random_traffic(860);
    test_full_rate(120);

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d requests and checked %0d results; the deque reached %0d entries.",
             requests_sent, results_seen, deepest_fill);
    $display("Seen %0d refused pushes, %0d reads of an empty deque and %0d flushes.",
             refused_pushes, empty_reads, flushes_done);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/rcd_pkg.sv
design/rcd_if.sv
design/rcd_mem.sv
design/rcd_ctrl.sv
design/read_command_deque.sv
bench/tb.sv
